// ----- hdl/owbs_pkg.sv -----
// Package: types, constants and helpers for the one-wire pulse-width byte sender.
package owbs_pkg;

  localparam int BITS_PER_FRAME = 8;
  localparam int TIMER_WIDTH    = 16;
  localparam int BYTE_W         = 8;
  localparam int REG_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int BITS_LEFT_W    = $clog2(BITS_PER_FRAME + 1);

  localparam logic [REG_W-1:0] START_HIGH_RST = REG_W'(10000);
  localparam logic [REG_W-1:0] START_LOW_RST  = REG_W'(2000);
  localparam logic [REG_W-1:0] LONG_RST       = REG_W'(2400);
  localparam logic [REG_W-1:0] SHORT_RST      = REG_W'(800);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_HIGH = 2'd0,
    REG_START_LOW  = 2'd1,
    REG_LONG       = 2'd2,
    REG_SHORT      = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_START_H = 5'b00010,
    PH_START_L = 5'b00100,
    PH_BIT_H   = 5'b01000,
    PH_BIT_L   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] speech_byte;
  } in_item_t;

  typedef struct packed {
    logic data_line;
    logic sending;
    logic rejected;
    logic amp_enable;
  } out_item_t;

  // Mask a duration to the timer width; zero lasts one tick.
  function automatic logic [TIMER_WIDTH-1:0] load_time(input logic [REG_W-1:0] ticks);
    logic [TIMER_WIDTH-1:0] t;
    t = TIMER_WIDTH'(ticks);
    load_time = (t == '0) ? TIMER_WIDTH'(1) : t;
  endfunction

endpackage

// ----- hdl/one_wire_pulse_width_byte_sender_top.sv -----
// Top level: pulse-width byte sender for a one-wire voice chip.
// An accepted transaction's result is registered in the output register.
// Throughput: one transaction per cycle while in_stall is low; the phase/timer update is one pass of logic.
// in_stall is raised only while a finished result waits and out_stall is high.
// Reset (synchronous, rst_n low): line high, idle, amp off, registers at defaults.
module one_wire_pulse_width_byte_sender_top
  import owbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata
);

  logic [REG_W-1:0] start_high_r, start_low_r, long_r, short_r;

  phase_t                 phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] time_left_r, time_left_nxt;
  logic [BITS_LEFT_W-1:0] bits_left_r, bits_left_nxt;
  logic [BYTE_W-1:0]      shift_r, shift_nxt;
  logic                   line_r, line_nxt;
  logic                   amp_r, amp_nxt;
  logic                   rejected;

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      accept;

  logic [BYTE_W-1:0]      shift_dn;
  logic [BITS_LEFT_W-1:0] bits_dn;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_high_r <= START_HIGH_RST;
      start_low_r  <= START_LOW_RST;
      long_r       <= LONG_RST;
      short_r      <= SHORT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_START_HIGH: start_high_r <= cfg_wdata;
        REG_START_LOW:  start_low_r  <= cfg_wdata;
        REG_LONG:       long_r       <= cfg_wdata;
        REG_SHORT:      short_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign shift_dn = shift_r >> 1;
  assign bits_dn  = (bits_left_r != '0) ? bits_left_r - BITS_LEFT_W'(1) : bits_left_r;

  always_comb begin
    phase_nxt     = phase_r;
    time_left_nxt = time_left_r;
    bits_left_nxt = bits_left_r;
    shift_nxt     = shift_r;
    line_nxt      = line_r;
    amp_nxt       = amp_r;
    rejected      = 1'b0;
    if (in_data.cmd) begin
      if (phase_r != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        amp_nxt       = 1'b1;
        shift_nxt     = in_data.speech_byte;
        bits_left_nxt = BITS_LEFT_W'(BITS_PER_FRAME);
        phase_nxt     = PH_START_H;
        line_nxt      = 1'b1;
        time_left_nxt = load_time(start_high_r);
      end
    end else if (phase_r != PH_IDLE) begin
      time_left_nxt = (time_left_r != '0) ? time_left_r - TIMER_WIDTH'(1) : time_left_r;
      if (time_left_r <= TIMER_WIDTH'(1)) begin
        unique case (phase_r)
          PH_START_H: begin
            phase_nxt     = PH_START_L;
            line_nxt      = 1'b0;
            time_left_nxt = load_time(start_low_r);
          end
          PH_START_L: begin
            phase_nxt     = PH_BIT_H;
            line_nxt      = 1'b1;
            time_left_nxt = load_time(shift_r[0] ? long_r : short_r);
          end
          PH_BIT_H: begin
            phase_nxt     = PH_BIT_L;
            line_nxt      = 1'b0;
            time_left_nxt = load_time(shift_r[0] ? short_r : long_r);
          end
          PH_BIT_L: begin
            shift_nxt     = shift_dn;
            bits_left_nxt = bits_dn;
            if (bits_dn != '0) begin
              phase_nxt     = PH_BIT_H;
              line_nxt      = 1'b1;
              time_left_nxt = load_time(shift_dn[0] ? long_r : short_r);
            end else begin
              phase_nxt     = PH_IDLE;
              line_nxt      = 1'b1;
              time_left_nxt = '0;
            end
          end
          default: begin
            phase_nxt     = PH_IDLE;
            line_nxt      = 1'b1;
            time_left_nxt = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      time_left_r <= '0;
      bits_left_r <= '0;
      shift_r     <= '0;
      line_r      <= 1'b1;
      amp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        time_left_r <= time_left_nxt;
        bits_left_r <= bits_left_nxt;
        shift_r     <= shift_nxt;
        line_r      <= line_nxt;
        amp_r       <= amp_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.data_line  <= line_nxt;
      out_data_r.sending    <= (phase_nxt != PH_IDLE);
      out_data_r.rejected   <= rejected;
      out_data_r.amp_enable <= amp_nxt;
    end
  end

  a_reject_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.rejected) |-> out_data_r.sending)
    else $error("rejected transaction reported while idle");

  a_idle_line_high: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (line_r && time_left_r == '0))
    else $error("line not high or timer running while idle");

  a_amp_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    amp_r |=> amp_r)
    else $error("amplifier enable dropped");

  a_timer_running: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (time_left_r != '0))
    else $error("timer empty during a frame");

endmodule

// ----- tb/tb_one_wire_pulse_width_byte_sender_top.sv -----
// Testbench: checks the pulse-width byte sender's line level, busy, reject and amp flags per transaction.
`timescale 1ns / 1ps
module tb_one_wire_pulse_width_byte_sender_top;
  import owbs_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 80;
  localparam logic [REG_W-1:0] LONG_HOLD = REG_W'(30);

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_wdata;

  one_wire_pulse_width_byte_sender_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Expected sender state
  phase_t                 line_phase;
  logic [TIMER_WIDTH-1:0] ticks_left;
  logic [BITS_LEFT_W-1:0] bits_left;
  logic [BYTE_W-1:0]      shift_byte;
  logic                   line_level;
  logic                   amp_on;
  logic [REG_W-1:0]       timing [4];

  out_item_t awaited_status [$];

  int  mismatches     = 0;
  int  items_sent     = 0;
  int  status_seen    = 0;
  int  frames_started = 0;
  int  plays_rejected = 0;
  bit  in_gaps_on     = 1'b1;
  bit  out_gaps_on    = 1'b1;
  bit  hold_req       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [TIMER_WIDTH-1:0] ticks_to_load(input logic [REG_W-1:0] v);
    logic [TIMER_WIDTH-1:0] t;
    t = TIMER_WIDTH'(v);
    return (t == '0) ? TIMER_WIDTH'(1) : t;
  endfunction

  function automatic out_item_t step_sender(input in_item_t it);
    out_item_t st;
    st = '0;
    if (it.cmd) begin
      if (line_phase != PH_IDLE) begin
        st.rejected = 1'b1;
      end else begin
        amp_on     = 1'b1;
        shift_byte = it.speech_byte;
        bits_left  = BITS_LEFT_W'(BITS_PER_FRAME);
        line_phase = PH_START_H;
        line_level = 1'b1;
        ticks_left = ticks_to_load(timing[REG_START_HIGH]);
      end
    end else if (line_phase != PH_IDLE) begin
      if (ticks_left != '0) ticks_left = ticks_left - TIMER_WIDTH'(1);
      if (ticks_left == '0) begin
        case (line_phase)
          PH_START_H: begin
            line_phase = PH_START_L;
            line_level = 1'b0;
            ticks_left = ticks_to_load(timing[REG_START_LOW]);
          end
          PH_START_L: begin
            line_phase = PH_BIT_H;
            line_level = 1'b1;
            ticks_left = ticks_to_load(shift_byte[0] ? timing[REG_LONG] : timing[REG_SHORT]);
          end
          PH_BIT_H: begin
            line_phase = PH_BIT_L;
            line_level = 1'b0;
            ticks_left = ticks_to_load(shift_byte[0] ? timing[REG_SHORT] : timing[REG_LONG]);
          end
          PH_BIT_L: begin
            shift_byte = shift_byte >> 1;
            if (bits_left != '0) bits_left = bits_left - BITS_LEFT_W'(1);
            if (bits_left != '0) begin
              line_phase = PH_BIT_H;
              line_level = 1'b1;
              ticks_left = ticks_to_load(shift_byte[0] ? timing[REG_LONG] : timing[REG_SHORT]);
            end else begin
              line_phase = PH_IDLE;
              line_level = 1'b1;
              ticks_left = '0;
            end
          end
          default: begin
            line_phase = PH_IDLE;
            line_level = 1'b1;
            ticks_left = '0;
          end
        endcase
      end
    end
    st.data_line  = line_level;
    st.sending    = (line_phase != PH_IDLE);
    st.amp_enable = amp_on;
    return st;
  endfunction

  task automatic compare_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %b, got %b", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_status
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      status_seen++;
      if (awaited_status.size() == 0) begin
        $error("line status transaction with none outstanding: %b", out_data);
        mismatches++;
      end else begin
        want = awaited_status.pop_front();
        compare_field("data_line", want.data_line, out_data.data_line);
        compare_field("sending", want.sending, out_data.sending);
        compare_field("rejected", want.rejected, out_data.rejected);
        compare_field("amp_enable", want.amp_enable, out_data.amp_enable);
      end
    end
  end

  // Receiver: random stalls, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= out_gaps_on && ($urandom_range(99) < 24);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $error("no transaction for %0d cycles", QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] b);
    in_item_t it;
    it.cmd         = cmd;
    it.speech_byte = b;
    @(negedge clk);
    while (in_gaps_on && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd) begin
      if (line_phase == PH_IDLE) frames_started++;
      else plays_rejected++;
    end
    awaited_status.push_back(step_sender(it));
    items_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic quiesce();
    stop_sending();
    while (awaited_status.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] v);
    quiesce();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    timing[idx] = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_timing(input logic [REG_W-1:0] sh, input logic [REG_W-1:0] sl,
                            input logic [REG_W-1:0] lg, input logic [REG_W-1:0] st);
    write_reg(REG_START_HIGH, sh);
    write_reg(REG_START_LOW, sl);
    write_reg(REG_LONG, lg);
    write_reg(REG_SHORT, st);
  endtask

  task automatic send_byte_frame(input logic [BYTE_W-1:0] b, input int reject_pct,
                                 input int write_pct);
    send_item(1'b1, b);
    while (line_phase != PH_IDLE) begin
      if ($urandom_range(99) < write_pct)
        write_reg(reg_idx_t'($urandom_range(3)), REG_W'($urandom_range(5)));
      if ($urandom_range(99) < reject_pct)
        send_item(1'b1, BYTE_W'($urandom));
      else
        send_item(1'b0, BYTE_W'($urandom));
    end
  endtask

  task automatic test_idle_ticks();
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h5A);
  endtask

  // First play sets the amp latch; a play while busy is turned away
  task automatic test_first_play();
    set_timing(16'd3, 16'd2, 16'd2, 16'd1);
    send_item(1'b1, 8'h01);
    send_item(1'b1, 8'hFE);
    while (line_phase != PH_BIT_L) send_item(1'b0, BYTE_W'($urandom));
    set_timing(16'd0, 16'd0, 16'd1, 16'd0);
    while (line_phase != PH_IDLE) send_item(1'b0, BYTE_W'($urandom));
  endtask

  task automatic test_zero_and_extreme_bytes();
    set_timing(16'd0, 16'd1, 16'd2, 16'd0);
    send_byte_frame(8'h00, 10, 0);
    send_byte_frame(8'hFF, 10, 0);
    send_byte_frame(8'h80, 0, 0);
    send_item(1'b0, 8'hFF);
    send_byte_frame(8'h01, 0, 0);
  endtask

  task automatic test_random_frames(input int n);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 20)
        write_reg(reg_idx_t'($urandom_range(3)), REG_W'($urandom_range(6)));
      if ($urandom_range(99) < 15)
        repeat ($urandom_range(1, 3)) send_item(1'b0, BYTE_W'($urandom));
      send_byte_frame(BYTE_W'($urandom), 5, 2);
    end
  endtask

  task automatic test_backpressure();
    set_timing(16'd3, 16'd3, 16'd4, 16'd2);
    hold_req = 1'b1;
    send_byte_frame(8'hC3, 5, 0);
  endtask

  // All four durations long, with mid-frame rewrites to finish sooner
  task automatic test_longest_durations();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    set_timing(LONG_HOLD, LONG_HOLD, LONG_HOLD, LONG_HOLD);
    send_item(1'b1, 8'h00);
    while (line_phase != PH_BIT_H) send_item(1'b0, BYTE_W'($urandom));
    write_reg(REG_SHORT, 16'd1);
    while (line_phase != PH_BIT_L) send_item(1'b0, BYTE_W'($urandom));
    write_reg(REG_LONG, 16'd2);
    while (line_phase != PH_IDLE) send_item(1'b0, BYTE_W'($urandom));
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_START_HIGH;
    cfg_wdata = '0;
    timing[REG_START_HIGH] = START_HIGH_RST;
    timing[REG_START_LOW]  = START_LOW_RST;
    timing[REG_LONG]       = LONG_RST;
    timing[REG_SHORT]      = SHORT_RST;
    line_phase = PH_IDLE;
    ticks_left = '0;
    bits_left  = '0;
    shift_byte = '0;
    line_level = 1'b1;
    amp_on     = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_ticks();
    test_first_play();
    test_zero_and_extreme_bytes();
    test_random_frames(250);
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    test_random_frames(100);
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    test_backpressure();
    test_longest_durations();

    stop_sending();
    while (awaited_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d transactions, checked %0d line status transactions", items_sent,
             status_seen);
    $display("Frames started %0d, plays rejected while busy %0d, durations 0 to %0d ticks",
             frames_started, plays_rejected, LONG_HOLD);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
